>>> hdl/htca_pkg.sv
// Shared types, constants and helpers for the humidity/temperature alarm unit.
package htca_pkg;

	localparam int TEMP_RAW_W = 14;
	localparam int RH_RAW_W   = 12;
	localparam int TEMP_OUT_W = 12;
	localparam int RH_OUT_W   = 10;
	localparam int LIMIT_W    = 10;
	localparam int STATUS_W   = 2;

	// floor(x / 10) == (x * RECIP10) >> RECIP10_SH for x below 43690
	localparam int RECIP10_W  = 16;
	localparam logic [RECIP10_W-1:0] RECIP10 = 16'd52429;
	localparam int RECIP10_SH = 19;

	localparam logic [LIMIT_W-1:0] TEMP_HIGH_RST = 10'd260;
	localparam logic [LIMIT_W-1:0] TEMP_LOW_RST  = 10'd240;
	localparam logic [LIMIT_W-1:0] RH_HIGH_RST   = 10'd700;
	localparam logic [LIMIT_W-1:0] RH_LOW_RST    = 10'd500;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_LOW  = 2'd1,
		STAT_HIGH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_TEMP_HIGH = 2'd0,
		REG_TEMP_LOW  = 2'd1,
		REG_RH_HIGH   = 2'd2,
		REG_RH_LOW    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TEMP_RAW_W-1:0] raw_temp;
		logic [RH_RAW_W-1:0]   raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_OUT_W-1:0] temp_tenths;
		logic [RH_OUT_W-1:0]          rh_tenths;
		logic [STATUS_W-1:0]          temp_status;
		logic [STATUS_W-1:0]          rh_status;
		logic                         alarm;
	} result_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] temp_high;
		logic [LIMIT_W-1:0] temp_low;
		logic [LIMIT_W-1:0] rh_high;
		logic [LIMIT_W-1:0] rh_low;
	} limits_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// high wins when the limits overlap
	function automatic status_t classify(logic signed [TEMP_OUT_W:0] v,
			logic [LIMIT_W-1:0] low, logic [LIMIT_W-1:0] high);
		logic signed [TEMP_OUT_W:0] lo_s;
		logic signed [TEMP_OUT_W:0] hi_s;
		lo_s = $signed({{(TEMP_OUT_W+1-LIMIT_W){1'b0}}, low});
		hi_s = $signed({{(TEMP_OUT_W+1-LIMIT_W){1'b0}}, high});
		if (v >= hi_s) begin
			return STAT_HIGH;
		end else if (v <= lo_s) begin
			return STAT_LOW;
		end
		return STAT_OK;
	endfunction

endpackage

>>> hdl/htca_temp_path.sv
// Temperature conversion pipeline: raw count to signed tenths of a degree.
module htca_temp_path (
	input  logic                                  clk,
	input  htca_pkg::pipe_en_t                    en,
	input  logic [htca_pkg::TEMP_RAW_W-1:0]       raw_temp,
	output logic signed [htca_pkg::TEMP_OUT_W-1:0] temp_s5
);
	import htca_pkg::*;

	localparam int DW = TEMP_RAW_W + 2;
	localparam int PW = TEMP_RAW_W + RECIP10_W;
	localparam int QW = TEMP_OUT_W - 1;
	localparam logic signed [DW-1:0] TEMP_OFS = DW'(4000);

	logic signed [DW-1:0]         diff;
	logic [TEMP_RAW_W-1:0]        mag;
	logic [PW-1:0]                prod;
	logic [QW-1:0]                quo;

	logic                         neg_s1;
	logic [TEMP_RAW_W-1:0]        mag_s1;
	logic                         neg_s2;
	logic [PW-1:0]                prod_s2;
	logic signed [TEMP_OUT_W-1:0] temp_s3;
	logic signed [TEMP_OUT_W-1:0] temp_s4;

	assign diff = $signed({2'b00, raw_temp}) - TEMP_OFS;
	assign mag  = diff[DW-1] ? TEMP_RAW_W'(-diff) : TEMP_RAW_W'(diff);
	assign prod = PW'(mag_s1) * PW'(RECIP10);
	assign quo  = prod_s2[RECIP10_SH +: QW];

	// divide the magnitude, then restore the sign: truncation toward zero
	always_ff @(posedge clk) begin
		if (en.s1) begin
			neg_s1 <= diff[DW-1];
			mag_s1 <= mag;
		end
		if (en.s2) begin
			neg_s2  <= neg_s1;
			prod_s2 <= prod;
		end
		if (en.s3) begin
			temp_s3 <= neg_s2 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		end
		if (en.s4) begin
			temp_s4 <= temp_s3;
		end
		if (en.s5) begin
			temp_s5 <= temp_s4;
		end
	end

endmodule

>>> hdl/htca_rh_path.sv
// Humidity pipeline: linearize, temperature-compensate, clamp and scale to tenths.
module htca_rh_path #(
	parameter int FRAC_BITS = 20
) (
	input  logic                              clk,
	input  htca_pkg::pipe_en_t                en,
	input  logic [htca_pkg::TEMP_RAW_W-1:0]   raw_temp,
	input  logic [htca_pkg::RH_RAW_W-1:0]     raw_humidity,
	output logic [htca_pkg::RH_OUT_W-1:0]     rh_s5
);
	import htca_pkg::*;

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint C2  = (405 * ONE + 5000) / 10000;
	localparam longint C3  = (28 * ONE + 5000000) / 10000000;
	localparam longint T1  = (ONE + 50) / 100;
	localparam longint T2  = (8 * ONE + 50000) / 100000;

	localparam int SW   = FRAC_BITS + 18;
	localparam int TH_W = FRAC_BITS;
	localparam int DT_W = TEMP_RAW_W + 2;
	localparam int HH_W = 2 * RH_RAW_W;
	localparam int XW   = 14;
	localparam int PW   = XW + RECIP10_W;

	// all humidity terms carry a factor of 100 * 2^FRAC_BITS
	localparam logic signed [SW-1:0] C1_100 = SW'(-400 * ONE);
	localparam logic signed [SW-1:0] C2_100 = SW'(100 * C2);
	localparam logic signed [SW-1:0] C3_100 = SW'(-100 * C3);
	localparam logic [TH_W-1:0]      T1_K   = TH_W'(T1);
	localparam logic [TH_W-1:0]      T2_K   = TH_W'(T2);
	localparam logic signed [DT_W-1:0] T25_OFS = DT_W'(6500);
	localparam logic signed [SW-1:0] RH_MIN = SW'(10);
	localparam logic signed [SW-1:0] RH_MAX = SW'(10000);

	logic signed [SW-1:0] s_int;
	logic [PW-1:0]        rh_prod;

	logic [HH_W-1:0]      hh_s1;
	logic [TH_W-1:0]      th_s1;
	logic signed [SW-1:0] lin_s1;
	logic signed [DT_W-1:0] dt_s1;
	logic signed [SW-1:0] comp_s2;
	logic signed [SW-1:0] quad_s2;
	logic signed [SW-1:0] lin_s2;
	logic signed [SW-1:0] sum_s3;
	logic [XW-1:0]        x_s4;

	assign s_int   = sum_s3 >>> FRAC_BITS;
	assign rh_prod = PW'(x_s4) * PW'(RECIP10);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			hh_s1  <= HH_W'(raw_humidity) * HH_W'(raw_humidity);
			th_s1  <= T2_K * TH_W'(raw_humidity) + T1_K;
			lin_s1 <= C2_100 * $signed({{(SW-RH_RAW_W){1'b0}}, raw_humidity}) + C1_100;
			dt_s1  <= $signed({2'b00, raw_temp}) - T25_OFS;
		end
		if (en.s2) begin
			comp_s2 <= $signed({{(SW-DT_W){dt_s1[DT_W-1]}}, dt_s1}) *
				$signed({{(SW-TH_W){1'b0}}, th_s1});
			quad_s2 <= C3_100 * $signed({{(SW-HH_W){1'b0}}, hh_s1});
			lin_s2  <= lin_s1;
		end
		if (en.s3) begin
			sum_s3 <= comp_s2 + quad_s2 + lin_s2;
		end
		// clamp bounds are whole units, so clamping the floored value is exact
		if (en.s4) begin
			if (s_int < RH_MIN) begin
				x_s4 <= XW'(RH_MIN);
			end else if (s_int > RH_MAX) begin
				x_s4 <= XW'(RH_MAX);
			end else begin
				x_s4 <= XW'(s_int);
			end
		end
		if (en.s5) begin
			rh_s5 <= rh_prod[RECIP10_SH +: RH_OUT_W];
		end
	end

endmodule

>>> hdl/htca_classify.sv
// Output stage: limit checks, alarm and the result register.
module htca_classify (
	input  logic                                   clk,
	input  logic                                   en,
	input  htca_pkg::limits_t                      limits,
	input  logic signed [htca_pkg::TEMP_OUT_W-1:0] temp_s5,
	input  logic [htca_pkg::RH_OUT_W-1:0]          rh_s5,
	output htca_pkg::result_t                      result_s6
);
	import htca_pkg::*;

	status_t t_stat;
	status_t h_stat;

	assign t_stat = classify({temp_s5[TEMP_OUT_W-1], temp_s5},
		limits.temp_low, limits.temp_high);
	assign h_stat = classify($signed({{(TEMP_OUT_W+1-RH_OUT_W){1'b0}}, rh_s5}),
		limits.rh_low, limits.rh_high);

	always_ff @(posedge clk) begin
		if (en) begin
			result_s6.temp_tenths <= temp_s5;
			result_s6.rh_tenths   <= rh_s5;
			result_s6.temp_status <= t_stat;
			result_s6.rh_status   <= h_stat;
			result_s6.alarm       <= (t_stat != STAT_OK) || (h_stat != STAT_OK);
		end
	end

endmodule

>>> hdl/humidity_temp_compensate_alarm_unit.sv
// Top level: six-stage pipeline, APB limit registers and request handshake.
// A request accepted at one edge enters stage 1 and advances through stages 2 to 6 to the result.
// Throughput: one request per cycle while result_ready does not stall the output.
// Stalls hold only the stages that are full, so empty stages still take requests.
// Reset clears all stage valid bits and loads the limits 260, 240, 700 and 500.
module humidity_temp_compensate_alarm_unit #(
	parameter int FRAC_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  htca_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output htca_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import htca_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	pipe_en_t en;
	limits_t  limits_q;
	reg_idx_t reg_idx;
	logic signed [TEMP_OUT_W-1:0] temp_s5;
	logic [RH_OUT_W-1:0]          rh_s5;
	logic                         wr_en;

	// a stage can load when it is empty or its successor moves
	assign rdy6 = !vld_s6 || result_ready;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5, s6: rdy6};
	assign sample_ready = rdy1;
	assign result_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= sample_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	htca_temp_path u_temp (
		.clk      (clk),
		.en       (en),
		.raw_temp (sample.raw_temp),
		.temp_s5  (temp_s5)
	);

	htca_rh_path #(
		.FRAC_BITS (FRAC_BITS)
	) u_rh (
		.clk          (clk),
		.en           (en),
		.raw_temp     (sample.raw_temp),
		.raw_humidity (sample.raw_humidity),
		.rh_s5        (rh_s5)
	);

	htca_classify u_classify (
		.clk       (clk),
		.en        (en.s6),
		.limits    (limits_q),
		.temp_s5   (temp_s5),
		.rh_s5     (rh_s5),
		.result_s6 (result)
	);

	// limit registers
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= '{temp_high: TEMP_HIGH_RST, temp_low: TEMP_LOW_RST,
				rh_high: RH_HIGH_RST, rh_low: RH_LOW_RST};
		end else if (wr_en) begin
			case (reg_idx)
				REG_TEMP_HIGH: limits_q.temp_high <= pwdata[LIMIT_W-1:0];
				REG_TEMP_LOW:  limits_q.temp_low  <= pwdata[LIMIT_W-1:0];
				REG_RH_HIGH:   limits_q.rh_high   <= pwdata[LIMIT_W-1:0];
				REG_RH_LOW:    limits_q.rh_low    <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TEMP_HIGH: prdata = 32'(limits_q.temp_high);
			REG_TEMP_LOW:  prdata = 32'(limits_q.temp_low);
			REG_RH_HIGH:   prdata = 32'(limits_q.rh_high);
			REG_RH_LOW:    prdata = 32'(limits_q.rh_low);
			default:       prdata = '0;
		endcase
	end

	a_alarm_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.alarm ==
			((result.temp_status != STAT_OK) || (result.rh_status != STAT_OK))))
		else $error("alarm disagrees with channel status");

	a_rh_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.rh_tenths >= 10'd1 && result.rh_tenths <= 10'd1000))
		else $error("humidity result outside clamp range");

	a_request_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> vld_s1)
		else $error("accepted request did not enter the first stage");

	a_stall_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

endmodule

>>> tb/sv/tb_humidity_temp_compensate_alarm_unit.sv
// Testbench for the humidity/temperature alarm unit: random and directed readings, checked against a local predictor.
module tb_humidity_temp_compensate_alarm_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import htca_pkg::*;

	localparam int Q_FRAC       = 20;
	localparam int SETTLE_GAP   = 20;
	localparam int STALL_LIMIT  = 2000;
	localparam int REPORT_LIMIT = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	sample_t     sample = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sample_t pending_samples[$];
	result_t expected_readings[$];
	limits_t cur_limits;
	int      send_idle_pct = 18;
	int      recv_idle_pct = 18;
	int      error_count = 0;
	int      stall_cycles = 0;

	humidity_temp_compensate_alarm_unit #(.FRAC_BITS(Q_FRAC)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// round(num/den * 2^Q), ties away from zero for non-negative num
	function automatic longint q_round(longint num, longint den);
		longint q_one;
		q_one = longint'(1) << Q_FRAC;
		return (num * q_one + den / 2) / den;
	endfunction

	// high wins over low when the limits overlap
	function automatic status_t grade_level(longint v, logic [LIMIT_W-1:0] low,
			logic [LIMIT_W-1:0] high);
		if (v >= longint'(high)) begin
			return STAT_HIGH;
		end else if (v <= longint'(low)) begin
			return STAT_LOW;
		end
		return STAT_OK;
	endfunction

	function automatic result_t predict_reading(sample_t s, limits_t lim);
		longint  q_one;
		longint  k_lin;
		longint  k_quad;
		longint  k_t1;
		longint  k_t2;
		longint  rt;
		longint  h;
		longint  tt;
		longint  lin;
		longint  acc;
		longint  rh;
		status_t ts;
		status_t hs;
		result_t r;
		q_one  = longint'(1) << Q_FRAC;
		k_lin  = q_round(405, 10000);
		k_quad = -q_round(28, 10000000);
		k_t1   = q_round(1, 100);
		k_t2   = q_round(8, 100000);
		rt = longint'(s.raw_temp);
		h  = longint'(s.raw_humidity);
		tt = (rt - 4000) / 10;
		if (tt > 2047) tt = 2047;
		if (tt < -2048) tt = -2048;
		// humidity held scaled by 100 * 2^Q
		lin = -4 * q_one + k_lin * h + k_quad * h * h;
		acc = (rt - 6500) * (k_t1 + k_t2 * h) + 100 * lin;
		if (acc > 10000 * q_one) acc = 10000 * q_one;
		if (acc < 10 * q_one) acc = 10 * q_one;
		rh = acc / (10 * q_one);
		ts = grade_level(tt, lim.temp_low, lim.temp_high);
		hs = grade_level(rh, lim.rh_low, lim.rh_high);
		r.temp_tenths = tt[TEMP_OUT_W-1:0];
		r.rh_tenths   = rh[RH_OUT_W-1:0];
		r.temp_status = ts;
		r.rh_status   = hs;
		r.alarm       = (ts != STAT_OK) || (hs != STAT_OK);
		return r;
	endfunction

	// driver: present the next queued request, predict it when it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (sample_valid && sample_ready) begin
				expected_readings.push_back(predict_reading(sample, cur_limits));
			end
			if (!sample_valid || sample_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					sample <= pending_samples.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_readings.size() == 0) begin
					if (error_count < REPORT_LIMIT) begin
						$display("unexpected result: temp %0d rh %0d", $signed(result.temp_tenths),
							result.rh_tenths);
					end
					error_count = error_count + 1;
				end else begin
					want = expected_readings.pop_front();
					if (result.temp_tenths !== want.temp_tenths ||
							result.rh_tenths !== want.rh_tenths ||
							result.temp_status !== want.temp_status ||
							result.rh_status !== want.rh_status ||
							result.alarm !== want.alarm) begin
						if (error_count < REPORT_LIMIT) begin
							$display({"mismatch: temp %0d/%0d rh %0d/%0d tstat %0d/%0d ",
								"hstat %0d/%0d alarm %0b/%0b (exp/act)"},
								$signed(want.temp_tenths), $signed(result.temp_tenths),
								want.rh_tenths, result.rh_tenths,
								want.temp_status, result.temp_status,
								want.rh_status, result.rh_status,
								want.alarm, result.alarm);
						end
						error_count = error_count + 1;
					end
				end
			end
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
					(psel && penable)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", stall_cycles);
				$display("tb_humidity_temp_compensate_alarm_unit: done, errors");
				$finish;
			end
		end
	end

	task automatic write_limit(reg_idx_t idx, logic [LIMIT_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// upper bits are junk the block must drop
		pwdata <= {22'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TEMP_HIGH: cur_limits.temp_high = val;
			REG_TEMP_LOW:  cur_limits.temp_low = val;
			REG_RH_HIGH:   cur_limits.rh_high = val;
			REG_RH_LOW:    cur_limits.rh_low = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(int th, int tl, int hh, int hl);
		write_limit(REG_TEMP_HIGH, LIMIT_W'(th));
		write_limit(REG_TEMP_LOW, LIMIT_W'(tl));
		write_limit(REG_RH_HIGH, LIMIT_W'(hh));
		write_limit(REG_RH_LOW, LIMIT_W'(hl));
	endtask

	task automatic queue_sample(int rt, int h);
		sample_t s;
		s.raw_temp = TEMP_RAW_W'(rt);
		s.raw_humidity = RH_RAW_W'(h);
		pending_samples.push_back(s);
	endtask

	// mostly uniform; some readings land right around a temperature limit
	task automatic queue_random(int count);
		int kind;
		int target;
		int rt;
		int h;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				rt = $urandom_range(0, 16383);
			end else begin
				target = (kind < 83) ? int'(cur_limits.temp_low) : int'(cur_limits.temp_high);
				target = target + $urandom_range(0, 6) - 3;
				rt = 4000 + 10 * target + $urandom_range(0, 9);
				if (rt > 16383) rt = 16383;
				if (rt < 0) rt = 0;
			end
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				h = $urandom_range(0, 200);
			end else if (kind < 16) begin
				h = $urandom_range(3900, 4095);
			end else begin
				h = $urandom_range(0, 4095);
			end
			queue_sample(rt, h);
		end
	endtask

	// hold until every request has come back, then let the pipe settle
	task automatic drain_results();
		while (pending_samples.size() != 0 || sample_valid || expected_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	initial begin
		int tl;
		int hl;
		cur_limits.temp_high = TEMP_HIGH_RST;
		cur_limits.temp_low  = TEMP_LOW_RST;
		cur_limits.rh_high   = RH_HIGH_RST;
		cur_limits.rh_low    = RH_LOW_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, truncation around zero, limit edges
		queue_sample(0, 0);
		queue_sample(16383, 4095);
		queue_sample(16383, 0);
		queue_sample(0, 4095);
		queue_sample(4000, 2048);
		queue_sample(3991, 1000);
		queue_sample(3989, 1000);
		queue_sample(4009, 1500);
		queue_sample(4010, 1500);
		queue_sample(6600, 1500);
		queue_sample(6400, 1500);
		queue_sample(6410, 1490);
		queue_sample(6590, 1480);
		queue_sample(6500, 1490);
		queue_sample(6500, 2140);
		queue_sample(6500, 2150);
		queue_sample(12000, 4095);
		queue_sample(1000, 50);
		drain_results();

		set_limits(0, 0, 0, 0);
		queue_random(60);
		drain_results();

		set_limits(999, 999, 999, 999);
		queue_random(60);
		drain_results();

		// overlapping limits: high must win
		set_limits(100, 900, 200, 800);
		queue_sample(5000, 1500);
		queue_sample(0, 0);
		queue_sample(16383, 4095);
		queue_random(60);
		drain_results();

		set_limits(1023, 0, 1023, 0);
		queue_random(60);
		drain_results();

		// long stretch with both sides always willing
		tl = $urandom_range(0, 600);
		hl = $urandom_range(0, 600);
		set_limits(tl + $urandom_range(0, 399), tl, hl + $urandom_range(0, 399), hl);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(250);
		drain_results();
		send_idle_pct = 18;
		recv_idle_pct = 18;

		set_limits($urandom_range(0, 999), $urandom_range(0, 999),
			$urandom_range(0, 999), $urandom_range(0, 999));
		queue_random(100);
		drain_results();
		queue_random(100);
		drain_results();

		error_count = error_count + expected_readings.size();
		if (error_count == 0) begin
			$display("tb_humidity_temp_compensate_alarm_unit: done, clean");
		end else begin
			$display("tb_humidity_temp_compensate_alarm_unit: done, errors");
		end
		$finish;
	end

endmodule
